FILE: rtl/core/qkd_pkg.sv
package qkd_pkg;

  // one sample tick of the knob lines plus software requests
  typedef struct packed {
    logic line_a;
    logic line_b;
    logic line_push;
    logic take_turn;
    logic write_click;
    logic click_value;
  } qkd_in_t;

  // reported flags for one sample tick
  typedef struct packed {
    logic turned_cw;
    logic turned_ccw;
    logic clicked;
  } qkd_out_t;

  // edge kinds, also the column of the edge table
  typedef enum logic [1:0] {
    COL_A_RISE = 2'd0,
    COL_B_RISE = 2'd1,
    COL_A_FALL = 2'd2,
    COL_B_FALL = 2'd3
  } edge_col_t;

  typedef logic [1:0] phase_t;

  localparam phase_t PHASE_REST  = 2'd0;
  localparam phase_t PHASE_ONE   = 2'd1;
  localparam phase_t PHASE_THREE = 2'd3;

  // next phase, rows by current phase, columns by edge kind
  localparam phase_t EDGE_NEXT [0:3][0:3] = '{
    '{2'd0, 2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd3, 2'd1, 2'd2, 2'd2},
    '{2'd3, 2'd0, 2'd2, 2'd3}
  };

  // phase tracking and sticky turn flags
  typedef struct packed {
    phase_t phase_now;
    phase_t first_phase;
    logic   first_valid;
    phase_t prior_phase;
    logic   prior_valid;
    logic   cw;
    logic   ccw;
  } turn_state_t;

  // one step of the edge table, with detent detection on return to rest
  function automatic turn_state_t edge_step(turn_state_t s, edge_col_t col);
    turn_state_t n;
    n             = s;
    n.prior_phase = s.phase_now;
    n.prior_valid = 1'b1;
    n.phase_now   = EDGE_NEXT[s.phase_now][col];
    if (!n.first_valid && (n.phase_now != PHASE_REST)) begin
      n.first_phase = n.phase_now;
      n.first_valid = 1'b1;
    end
    if ((n.phase_now == PHASE_REST) && n.first_valid && n.prior_valid) begin
      if ((n.first_phase == PHASE_ONE) && (n.prior_phase == PHASE_THREE)) begin
        n.cw = 1'b1;
      end else if ((n.first_phase == PHASE_THREE) && (n.prior_phase == PHASE_ONE)) begin
        n.ccw = 1'b1;
      end
      n.first_phase = PHASE_REST;
      n.first_valid = 1'b0;
      n.prior_phase = PHASE_REST;
      n.prior_valid = 1'b0;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/qkd_track.sv
module qkd_track
  import qkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  qkd_in_t  item,
  output qkd_out_t flags
);

  logic        primed;
  logic        last_a;
  logic        last_b;
  logic        last_push;
  logic        click_latch;
  turn_state_t turn;

  turn_state_t turn_a;
  turn_state_t turn_b;
  turn_state_t turn_next;
  logic        click_mid;
  logic        click_next;

  // edge on A first, then edge on B, from the stored previous levels
  always_comb begin
    turn_a = turn;
    if (primed && (item.line_a != last_a)) begin
      turn_a = edge_step(turn, item.line_a ? COL_A_RISE : COL_A_FALL);
    end
    turn_b = turn_a;
    if (primed && (item.line_b != last_b)) begin
      turn_b = edge_step(turn_a, item.line_b ? COL_B_RISE : COL_B_FALL);
    end
  end

  // push falling edge sets the click, then a software write overrides
  always_comb begin
    click_mid = click_latch;
    if (primed && (item.line_push != last_push) && !item.line_push) begin
      click_mid = 1'b1;
    end
    click_next = item.write_click ? item.click_value : click_mid;
  end

  // flags are reported before take_turn clears them
  always_comb begin
    flags.turned_cw  = turn_b.cw;
    flags.turned_ccw = turn_b.ccw;
    flags.clicked    = click_next;
    turn_next        = turn_b;
    if (item.take_turn) begin
      turn_next.cw  = 1'b0;
      turn_next.ccw = 1'b0;
    end
  end

  // state update per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      primed      <= 1'b0;
      last_a      <= 1'b0;
      last_b      <= 1'b0;
      last_push   <= 1'b1;
      click_latch <= 1'b0;
      turn        <= '0;
    end else if (fire) begin
      primed      <= 1'b1;
      last_a      <= item.line_a;
      last_b      <= item.line_b;
      last_push   <= item.line_push;
      click_latch <= click_next;
      turn        <= turn_next;
    end
  end

endmodule

FILE: rtl/core/quadrature_knob_decoder.sv
// an accepted sample beat passes the input register, then the result register
// throughput: one sample beat per cycle while result_stall is low, set by the
// state update between the input register and the result register
// reset (synchronous, rst high): both registers empty, lines unprimed,
// phase at rest, turn flags and click latch cleared
module quadrature_knob_decoder
  import qkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_stall,
  input  qkd_in_t  sample,
  output logic     result_valid,
  input  logic     result_stall,
  output qkd_out_t result
);

  logic     in_vld;
  qkd_in_t  in_item;
  logic     advance;
  qkd_out_t flags;

  // move the held sample into the result register when it has room
  assign advance      = in_vld && (!result_valid || !result_stall);
  assign sample_stall = in_vld && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!sample_stall) begin
      in_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      in_item <= sample;
    end
  end

  // decoder state and flag update
  qkd_track u_track (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (in_item),
    .flags (flags)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= flags;
    end
  end

endmodule
